@@ design/bmd_pkg.sv @@
`default_nettype none

package bmd_pkg;

	// storage geometry
	localparam int DEPTH       = 32;
	localparam int MAX_RESULTS = 32;
	localparam int CAP_LIM     = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
	localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CAP_W       = 6;
	localparam int VAL_W       = 32;
	localparam int RND_W       = 32;
	localparam int ENT_W       = VAL_W + RND_W;

	typedef enum logic {
		CMD_PUSH  = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CAUSE_BEATEN  = 2'd0,
		CAUSE_EVICTED = 2'd1,
		CAUSE_DRAINED = 2'd2
	} cause_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [VAL_W-1:0]  value;
	} item_t;

	typedef struct packed {
		logic [RND_W-1:0]  removed_round;
		cause_t            cause;
		logic              last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_WRITE,
		ST_FLUSH
	} state_t;

	// clamp a written capacity into 1 .. CAP_LIM
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (c > CAP_W'(CAP_LIM)) begin
			r = CNT_W'(CAP_LIM);
		end else begin
			r = CNT_W'(c);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/bmd_ram.sv @@
`default_nettype none

module bmd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                                      clk,
	input  wire logic                                      wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                          wr_data,
	input  wire logic                                      rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/bounded_monotonic_deque.sv @@
`default_nettype none

// Bounded monotonic deque. A push (cmd 0) removes from the rear every entry
// whose value is strictly below the new value, reporting each entry's arrival
// round with cause 0; if none was removed and the deque holds capacity entries,
// the oldest entry is evicted from the front with cause 1. The new value is then
// appended with the current round and the round counter advances (starting at 1,
// wrapping at 2^32). A drain (cmd 1) reports every entry rear to front with
// cause 2, empties the deque and restarts the round count at 1. The final result
// of each item carries last = 1; an item may produce no result at all. Writing
// capacity (clamped to 1..32) empties the deque and restarts the round count.
// Entries live in a single-port-read RAM, and each entry examined passes
// through a read state and an evaluate state. A push reads the entries
// removed, plus the one that stops the scan, plus the evicted one, and a drain
// reads every entry; item_stall is high while an item is being processed,
// and also while a capacity write is offered, so that write goes first.
// Results leave through an output register, so a stalled result only holds the
// sequencer when a second result is ready behind it.
module bounded_monotonic_deque (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_stall,
	input  wire bmd_pkg::item_t           item,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output bmd_pkg::result_t              result,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [bmd_pkg::CAP_W-1:0] cfg_data
);

	import bmd_pkg::*;

	state_t             state_q, state_nx;
	logic [CNT_W-1:0]   cap_q;
	logic [PTR_W-1:0]   front_q, rear_q;
	logic [CNT_W-1:0]   count_q;
	logic [RND_W-1:0]   round_q;
	cmd_t               cmd_q;
	logic [VAL_W-1:0]   val_q;
	logic               any_q, evict_q;

	logic               pend_valid_q;
	logic [RND_W-1:0]   pend_round_q;
	cause_t             pend_cause_q;

	logic               result_valid_q;
	result_t            result_q;

	logic               ram_rd_en, ram_wr_en;
	logic [PTR_W-1:0]   ram_rd_addr;
	logic [ENT_W-1:0]   ram_rd_data;

	logic [PTR_W-1:0]   cap_m1, rear_inc, rear_dec, front_inc;
	logic [VAL_W-1:0]   ent_value;
	logic [RND_W-1:0]   ent_round;
	logic               item_acc, cfg_acc, out_free, slot_ok;
	logic               hit, produce, more, last_one;
	cause_t             ent_cause;
	logic               flush_load, out_load;
	logic [CNT_W-1:0]   cfg_cap;

	// ring arithmetic over the effective capacity
	assign cap_m1    = PTR_W'(cap_q - CNT_W'(1));
	assign rear_inc  = (rear_q == cap_m1) ? '0 : rear_q + PTR_W'(1);
	assign rear_dec  = (rear_q == '0) ? cap_m1 : rear_q - PTR_W'(1);
	assign front_inc = (front_q == cap_m1) ? '0 : front_q + PTR_W'(1);
	assign cfg_cap   = eff_cap(cfg_data);

	assign ent_value = ram_rd_data[ENT_W-1:RND_W];
	assign ent_round = ram_rd_data[RND_W-1:0];

	assign item_acc = item_valid && !item_stall;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign out_free = !result_valid_q || !result_stall;
	assign slot_ok  = !pend_valid_q || out_free;

	// entry evaluation
	assign hit      = (cmd_q == CMD_DRAIN) || evict_q || (ent_value < val_q);
	assign produce  = (state_q == ST_EVAL) && hit && slot_ok;
	assign last_one = (count_q == CNT_W'(1));
	assign more     = !last_one;

	always_comb begin
		priority if (cmd_q == CMD_DRAIN) begin
			ent_cause = CAUSE_DRAINED;
		end else if (evict_q) begin
			ent_cause = CAUSE_EVICTED;
		end else begin
			ent_cause = CAUSE_BEATEN;
		end
	end

	assign flush_load = (state_q == ST_FLUSH) && pend_valid_q && out_free;
	assign out_load   = (produce && pend_valid_q) || flush_load;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && !cfg_acc) begin
					if (count_q != '0) begin
						state_nx = ST_READ;
					end else if (item.cmd == CMD_DRAIN) begin
						state_nx = ST_FLUSH;
					end else begin
						state_nx = ST_WRITE;
					end
				end
			end
			ST_READ: begin
				state_nx = ST_EVAL;
			end
			ST_EVAL: begin
				if (!hit) begin
					if (!any_q && count_q == cap_q) begin
						state_nx = ST_READ;
					end else begin
						state_nx = ST_WRITE;
					end
				end else if (slot_ok) begin
					if (evict_q) begin
						state_nx = ST_WRITE;
					end else if (more) begin
						state_nx = ST_READ;
					end else if (cmd_q == CMD_DRAIN) begin
						state_nx = ST_FLUSH;
					end else begin
						state_nx = ST_WRITE;
					end
				end
			end
			ST_WRITE: begin
				state_nx = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		item_stall  = (state_q != ST_IDLE) || cfg_valid;
		cfg_ready   = (state_q == ST_IDLE);
		ram_rd_en   = (state_q == ST_READ);
		ram_rd_addr = evict_q ? front_q : rear_q;
		ram_wr_en   = (state_q == ST_WRITE);
	end

	bmd_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (rear_inc),
		.wr_data ({val_q, round_q}),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// sequencer and deque state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CNT_W'(CAP_LIM);
			front_q      <= '0;
			rear_q       <= PTR_W'(CAP_LIM - 1);
			count_q      <= '0;
			round_q      <= RND_W'(1);
			cmd_q        <= CMD_PUSH;
			any_q        <= 1'b0;
			evict_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			priority if (cfg_acc) begin
				cap_q   <= cfg_cap;
				front_q <= '0;
				rear_q  <= PTR_W'(cfg_cap - CNT_W'(1));
				count_q <= '0;
				round_q <= RND_W'(1);
			end else if (item_acc) begin
				cmd_q   <= item.cmd;
				any_q   <= 1'b0;
				evict_q <= 1'b0;
				if (item.cmd == CMD_DRAIN) begin
					round_q <= RND_W'(1);
				end
			end else if (state_q == ST_EVAL) begin
				if (!hit && !any_q && count_q == cap_q) begin
					evict_q <= 1'b1;
				end
				if (produce) begin
					pend_valid_q <= 1'b1;
					count_q      <= count_q - CNT_W'(1);
					if (evict_q) begin
						front_q <= front_inc;
						evict_q <= 1'b0;
					end else begin
						rear_q <= rear_dec;
						any_q  <= 1'b1;
					end
				end
			end else if (state_q == ST_WRITE) begin
				rear_q  <= rear_inc;
				count_q <= count_q + CNT_W'(1);
				round_q <= round_q + RND_W'(1);
			end else if (flush_load) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			val_q <= item.value;
		end
		if (produce) begin
			pend_round_q <= ent_round;
			pend_cause_q <= ent_cause;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.removed_round <= pend_round_q;
			result_q.cause         <= pend_cause_q;
			result_q.last          <= flush_load;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

@@ tb/tb_bounded_monotonic_deque.sv @@
`timescale 1ns / 100ps

module tb_bounded_monotonic_deque;
	import bmd_pkg::*;

	localparam int IDLE_LIMIT       = 4000;
	localparam int SETTLE_CYCLES    = 100;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic [RND_W-1:0] round;
	} entry_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	item_t            item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data     = '0;

	// deque shadow: index 0 is the front (oldest), the last element is the rear
	entry_t           held[$];
	logic [RND_W-1:0] next_round = 1;
	int               cap_limit  = CAP_LIM;

	result_t          removal_q[$];
	item_t            item_plan[$];
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               mismatches    = 0;
	int               idle_cycles   = 0;

	bounded_monotonic_deque dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// expected removals for one accepted item, appended in removal order
	function automatic void predict_removals(input item_t it);
		result_t r;
		int      n;
		n = 0;
		r.last = 1'b0;
		if (it.cmd == CMD_DRAIN) begin
			while (held.size() > 0) begin
				r.removed_round = held[$].round;
				r.cause = CAUSE_DRAINED;
				removal_q.push_back(r);
				void'(held.pop_back());
				n++;
			end
			next_round = 1;
		end else begin
			// strictly smaller entries at the rear are beaten
			while (held.size() > 0 && held[$].value < it.value) begin
				r.removed_round = held[$].round;
				r.cause = CAUSE_BEATEN;
				removal_q.push_back(r);
				void'(held.pop_back());
				n++;
			end
			// full and nothing beaten: oldest goes out the front
			if (n == 0 && held.size() >= cap_limit) begin
				r.removed_round = held[0].round;
				r.cause = CAUSE_EVICTED;
				removal_q.push_back(r);
				void'(held.pop_front());
				n++;
			end
			held.push_back('{value: it.value, round: next_round});
			next_round = next_round + 1'b1;
		end
		if (n > 0) removal_q[removal_q.size() - 1].last = 1'b1;
	endfunction

	task automatic note_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES) begin
			$display("%0t: %s: expected round %0d cause %0d last %0b, got round %0d cause %0d last %0b",
				$time, what, want.removed_round, want.cause, want.last,
				got.removed_round, got.cause, got.last);
		end
	endtask

	task automatic plan_item(input cmd_t cmd, input logic [VAL_W-1:0] v);
		item_plan.push_back('{cmd: cmd, value: v});
	endtask

	// capacity write; only called while the block is quiet
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		@(posedge clk);
		cfg_data  <= c;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_limit = (c == 0) ? 1 : ((c > CAP_LIM) ? CAP_LIM : int'(c));
		held.delete();
		next_round = 1;
	endtask

	// block until every planned beat went in and every removal came out
	task automatic wait_quiet();
		while (item_plan.size() > 0 || item_valid || removal_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		// a beat launched on the last check may still be in flight
		while (item_valid || removal_q.size() > 0 || result_valid) @(posedge clk);
	endtask

	// mostly descending runs that fill the deque, then sometimes a climber that beats them
	task automatic plan_random(input int n_items);
		logic [VAL_W-1:0] v;
		int               pick;
		int               run;
		int               planned;
		planned = 0;
		while (planned < n_items) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				plan_item(CMD_DRAIN, $urandom);
				planned++;
			end else if (pick < 55) begin
				run = $urandom_range(1, cap_limit + 2);
				v = $urandom;
				for (int i = 0; i < run; i++) begin
					plan_item(CMD_PUSH, v);
					pick = $urandom_range(3);
					v = (v > pick) ? v - pick : '0;
				end
				planned += run;
				if ($urandom_range(1)) begin
					v = $urandom_range(1) ? ($urandom | 32'h8000_0000) : v + $urandom_range(1, 64);
					plan_item(CMD_PUSH, v);
					planned++;
				end
			end else if (pick < 80) begin
				plan_item(CMD_PUSH, $urandom_range(7));
				planned++;
			end else begin
				plan_item(CMD_PUSH, $urandom);
				planned++;
			end
		end
	endtask

	// item driver: valid held until the beat is taken
	always @(posedge clk) begin
		item_t nxt_item;
		logic  nxt_valid;
		nxt_item  = item;
		nxt_valid = item_valid;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				predict_removals(item);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && item_plan.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt_item  = item_plan.pop_front();
				nxt_valid = 1'b1;
			end
		end
		item_valid <= nxt_valid;
		item       <= nxt_item;
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (removal_q.size() == 0) begin
				note_mismatch("unexpected result", '0, result);
			end else begin
				want = removal_q.pop_front();
				if (result.removed_round !== want.removed_round || result.cause !== want.cause ||
				    result.last !== want.last) begin
					note_mismatch("result mismatch", want, result);
				end
			end
		end
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [CAP_W-1:0] cap_seq [8];
		cap_seq = '{6'd0, 6'd63, 6'd2, 6'd33, 6'd1, 6'd3, 6'd0, 6'd32};
		cap_seq[5] = $urandom_range(3, 31);
		cap_seq[6] = $urandom_range(0, 63);

		send_idle_pct = 14;
		recv_idle_pct = 87;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset capacity: empty drain, extremes, ties, climbers
		plan_item(CMD_DRAIN, 32'h0);
		plan_item(CMD_PUSH, 32'hFFFF_FFFF);
		plan_item(CMD_PUSH, 32'hFFFF_FFFF);
		plan_item(CMD_PUSH, 32'h0);
		plan_item(CMD_PUSH, 32'h0);
		plan_item(CMD_PUSH, 32'h5);
		plan_item(CMD_PUSH, 32'hFFFF_FFFF);
		plan_item(CMD_PUSH, 32'h8000_0000);
		plan_item(CMD_PUSH, 32'h7FFF_FFFF);
		plan_item(CMD_PUSH, 32'h1);
		plan_item(CMD_DRAIN, 32'hFFFF_FFFF);
		plan_item(CMD_PUSH, 32'h5555_5555);
		plan_item(CMD_PUSH, 32'hAAAA_AAAA);
		plan_item(CMD_DRAIN, 32'h0);
		wait_quiet();

		// directed, small capacity: eviction, eviction on a tie, full pop-out
		write_capacity(6'd3);
		plan_item(CMD_PUSH, 32'd9);
		plan_item(CMD_PUSH, 32'd8);
		plan_item(CMD_PUSH, 32'd7);
		plan_item(CMD_PUSH, 32'd6);
		plan_item(CMD_PUSH, 32'd6);
		plan_item(CMD_PUSH, 32'hFFFF_FFFF);
		plan_item(CMD_DRAIN, 32'h0);
		wait_quiet();

		// random phases across capacity settings and idle regimes
		for (int p = 0; p < 8; p++) begin
			if (p == 3) begin
				send_idle_pct = 87;
				recv_idle_pct = 14;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_capacity(cap_seq[p]);
			plan_random(20 + cap_limit);
			wait_quiet();
		end

		while (removal_q.size() > 0) note_mismatch("missing result", removal_q.pop_front(), 'x);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
